>>> src/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared types, constants and controller/datapath handshake structs for the
// weighted contiguous partition unit.
// ----------------------------------------------------------------------------
package wcp_pkg;

  localparam int MAX_DEVICES = 64;
  localparam int MAX_BLOCKS  = 4096;
  localparam int DEV_W       = $clog2(MAX_DEVICES);      // device index
  localparam int CNT_W       = $clog2(MAX_DEVICES) + 1;  // device count
  localparam int BLK_W       = $clog2(MAX_BLOCKS);       // block address
  localparam int BCNT_W      = $clog2(MAX_BLOCKS) + 1;   // block count
  localparam int FAC_W       = 8;
  localparam int COST_W      = 32;
  localparam int REF_W       = 40;
  localparam int TOT_W       = 52;
  localparam int FSUM_W      = 14;
  localparam int ACC_W       = TOT_W + 1;
  localparam int DIV_STEPS   = TOT_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_SET_FACTOR = 2'd0;
  localparam logic [1:0] OP_LOAD_BLOCK = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [DEV_W-1:0]  device_index;
    logic [FAC_W-1:0]  device_factor;
    logic [COST_W-1:0] block_cost;
    logic [FAC_W-1:0]  owner_factor;
  } wcp_in_t;

  typedef struct packed {
    logic [DEV_W-1:0]  out_device;
    logic [BCNT_W-1:0] range_start;
    logic [BCNT_W-1:0] range_end;
    logic              last;
  } wcp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SUM_WAIT,
    ST_SUM_ACC,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_DEV_RD,
    ST_DEV_F,
    ST_BLK_CHK,
    ST_BLK_DIV,
    ST_BLK_WAIT,
    ST_EMIT
  } wcp_state_t;

  typedef struct packed {
    logic factor_wr;
    logic load_mul;
    logic load_wr;
    logic run_init;
    logic sum_acc;
    logic avg_start;
    logic avg_take;
    logic dev_init;
    logic dev_f;
    logic blk_start;
    logic blk_sat;
    logic blk_take;
    logic emit;
  } wcp_cmd_t;

  typedef struct packed {
    logic dev_last;
    logic blk_more;
    logic f_zero;
    logic div_done;
    logic out_free;
  } wcp_status_t;

endpackage

>>> src/wcp_divider.sv
// ----------------------------------------------------------------------------
// wcp_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// average and the per-block cost division.
// ----------------------------------------------------------------------------
module wcp_divider
  import wcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TOT_W-1:0]  dividend,
  input  logic [FSUM_W-1:0] divisor,
  output logic              done,
  output logic [TOT_W-1:0]  quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TOT_W-1:0]  quo_r, quo_nxt;
  logic [FSUM_W-1:0] rem_r, rem_nxt;
  logic [FSUM_W-1:0] dvs_r, dvs_nxt;
  logic [FSUM_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, quo_r[TOT_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? FSUM_W'(trial - {1'b0, dvs_r}) : trial[FSUM_W-1:0];
      quo_nxt  = {quo_r[TOT_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> src/wcp_datapath.sv
// ----------------------------------------------------------------------------
// wcp_datapath
// Factor and cost stores, running totals, partition counters and the
// result register.
// ----------------------------------------------------------------------------
module wcp_datapath
  import wcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  wcp_cmd_t         cmd,
  output wcp_status_t      status,
  input  wcp_in_t          in_data,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  output logic             out_valid,
  input  logic             out_stall,
  output wcp_out_t         out_data
);

  logic [FAC_W-1:0] factor_mem [MAX_DEVICES];
  logic [REF_W-1:0] ref_mem    [MAX_BLOCKS];
  logic [FAC_W-1:0] factor_rd_r;
  logic [REF_W-1:0] ref_rd_r;

  logic [CNT_W-1:0]  dev_count_r;
  logic [BCNT_W-1:0] loaded_r;
  logic [TOT_W-1:0]  total_r;
  logic [REF_W-1:0]  prod_r;
  logic [CNT_W-1:0]  dev_r;
  logic [FSUM_W-1:0] fsum_r;
  logic [TOT_W-1:0]  avg_r;
  logic [ACC_W-1:0]  acc_r;
  logic [BCNT_W-1:0] id_r;
  logic [BCNT_W-1:0] start_r;
  logic [FAC_W-1:0]  f_r;
  logic              out_valid_r;
  wcp_out_t          out_data_r;

  logic [CNT_W-1:0]  active;
  logic              div_start;
  logic [TOT_W-1:0]  div_dividend;
  logic [FSUM_W-1:0] div_divisor;
  logic              div_done;
  logic [TOT_W-1:0]  div_quo;

  // clamp the device count into 1..MAX_DEVICES
  always_comb begin
    if (dev_count_r == '0) begin
      active = CNT_W'(1);
    end else if (dev_count_r > CNT_W'(MAX_DEVICES)) begin
      active = CNT_W'(MAX_DEVICES);
    end else begin
      active = dev_count_r;
    end
  end

  assign div_start    = cmd.avg_start | cmd.blk_start;
  assign div_dividend = cmd.avg_start ? total_r : TOT_W'(ref_rd_r);
  assign div_divisor  = cmd.avg_start ? fsum_r : FSUM_W'(f_r);

  wcp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign status.dev_last = (dev_r == active - 1'b1);
  assign status.blk_more = (acc_r < ACC_W'(avg_r)) && (id_r < loaded_r);
  assign status.f_zero   = (f_r == '0);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.factor_wr) begin
      factor_mem[in_data.device_index] <= in_data.device_factor;
    end
    factor_rd_r <= factor_mem[dev_r[DEV_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && (loaded_r < BCNT_W'(MAX_BLOCKS))) begin
      ref_mem[loaded_r[BLK_W-1:0]] <= prod_r;
    end
    ref_rd_r <= ref_mem[id_r[BLK_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r <= CNT_W'(1);
      loaded_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dev_count_r <= cfg_wr_data;
      end
      // drop the full-store load silently
      if (cmd.load_wr && (loaded_r < BCNT_W'(MAX_BLOCKS))) begin
        loaded_r <= loaded_r + 1'b1;
        total_r  <= total_r + TOT_W'(prod_r);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      prod_r <= REF_W'(in_data.block_cost) * REF_W'(in_data.owner_factor);
    end
    if (cmd.run_init) begin
      dev_r  <= '0;
      fsum_r <= '0;
    end
    if (cmd.sum_acc) begin
      fsum_r <= fsum_r + FSUM_W'(factor_rd_r);
      dev_r  <= dev_r + 1'b1;
    end
    if (cmd.avg_take) begin
      avg_r <= (fsum_r == '0) ? '0 : div_quo;
      dev_r <= '0;
      id_r  <= '0;
    end
    if (cmd.dev_init) begin
      acc_r   <= '0;
      start_r <= id_r;
    end
    if (cmd.dev_f) begin
      f_r <= factor_rd_r;
    end
    if (cmd.blk_sat) begin
      acc_r <= acc_r + ACC_W'({REF_W{1'b1}});
      id_r  <= id_r + 1'b1;
    end
    if (cmd.blk_take) begin
      acc_r <= acc_r + ACC_W'(div_quo);
      id_r  <= id_r + 1'b1;
    end
    if (cmd.emit) begin
      out_data_r.out_device  <= dev_r[DEV_W-1:0];
      out_data_r.range_start <= start_r;
      out_data_r.range_end   <= status.dev_last ? loaded_r : id_r;
      out_data_r.last        <= status.dev_last;
      dev_r                  <= dev_r + 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/wcp_controller.sv
// ----------------------------------------------------------------------------
// wcp_controller
// Sequencer for loads, factor summing, average division and the greedy
// block walk.
// ----------------------------------------------------------------------------
module wcp_controller
  import wcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  wcp_status_t status,
  output wcp_cmd_t    cmd
);

  wcp_state_t state_r, state_nxt;
  logic       take;

  assign in_stall = (state_r != ST_IDLE);
  assign take     = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          unique case (in_op)
            OP_SET_FACTOR: cmd.factor_wr = 1'b1;
            OP_LOAD_BLOCK: begin
              cmd.load_mul = 1'b1;
              state_nxt    = ST_LOAD;
            end
            OP_RUN: begin
              cmd.run_init = 1'b1;
              state_nxt    = ST_SUM_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_SUM_WAIT: state_nxt = ST_SUM_ACC;
      ST_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        state_nxt   = status.dev_last ? ST_AVG_START : ST_SUM_WAIT;
      end
      ST_AVG_START: begin
        cmd.avg_start = 1'b1;
        state_nxt     = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (status.div_done) begin
          cmd.avg_take = 1'b1;
          state_nxt    = ST_DEV_RD;
        end
      end
      ST_DEV_RD: begin
        cmd.dev_init = 1'b1;
        state_nxt    = ST_DEV_F;
      end
      ST_DEV_F: begin
        cmd.dev_f = 1'b1;
        state_nxt = status.dev_last ? ST_EMIT : ST_BLK_CHK;
      end
      ST_BLK_CHK: state_nxt = status.blk_more ? ST_BLK_DIV : ST_EMIT;
      ST_BLK_DIV: begin
        // zero factor saturates without a division
        if (status.f_zero) begin
          cmd.blk_sat = 1'b1;
          state_nxt   = ST_BLK_CHK;
        end else begin
          cmd.blk_start = 1'b1;
          state_nxt     = ST_BLK_WAIT;
        end
      end
      ST_BLK_WAIT: begin
        if (status.div_done) begin
          cmd.blk_take = 1'b1;
          state_nxt    = ST_BLK_CHK;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = status.dev_last ? ST_IDLE : ST_DEV_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> src/weighted_contiguous_partition_unit.sv
// ----------------------------------------------------------------------------
// weighted_contiguous_partition_unit
// Splits loaded block costs into contiguous per-device ranges by speed factor.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_stall, results leave on out_valid/
// out_stall; cfg_wr_en/cfg_wr_data set the device count, which the user must
// write only while idle; the block does not enforce it. A set-factor item is
// written as it is taken; a load item multiplies, then stores and totals. A
// run is accepted, sums the factors, divides the cost total by the factor
// sum, then walks the blocks of each device but the last on the shared
// one-bit-per-cycle divider and emits one range per device.
// One item is worked at a time; in_stall is high until it is done.
// Results pass through one output register; a stalled receiver holds it and
// the walk waits at the next range. Reset empties the block store, clears the
// cost total and sets the device count to 1; factors are undefined until set.
// ----------------------------------------------------------------------------
module weighted_contiguous_partition_unit
  import wcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  wcp_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output wcp_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  wcp_cmd_t    cmd;
  wcp_status_t status;

  wcp_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_data.op),
    .status   (status),
    .cmd      (cmd)
  );

  wcp_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

>>> tb/weighted_contiguous_partition_unit_test.sv
// ----------------------------------------------------------------------------
// weighted_contiguous_partition_unit_test
// Self-checking bench for the weighted contiguous partition unit. Factor
// writes, block loads and run commands go in through the input channel. A
// local model of the factor table, block store and cost total predicts every
// range of each run. A checker compares each result transfer with the oldest
// prediction. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module weighted_contiguous_partition_unit_test;
  import wcp_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  wcp_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  wcp_out_t         out_data;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  weighted_contiguous_partition_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Local copy of the block state
  logic [FAC_W-1:0] factor_tbl [MAX_DEVICES];
  logic [REF_W-1:0] ref_cost   [MAX_BLOCKS];
  int unsigned      blk_count;
  logic [TOT_W-1:0] cost_sum;
  logic [6:0]       dev_count;

  wcp_out_t    range_q[$];
  int unsigned fail_count;
  int unsigned range_count;
  int unsigned run_count;
  int unsigned item_count;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("tb: failure");
    $finish;
  end

  // Work out the ranges of one run command
  task automatic predict_partition();
    int unsigned      n;
    int unsigned      id;
    int unsigned      start;
    logic [63:0]      fsum;
    logic [63:0]      avg;
    logic [63:0]      acc;
    logic [FAC_W-1:0] f;
    wcp_out_t         r;
    n = (dev_count == 0) ? 1 : dev_count;
    if (n > MAX_DEVICES) n = MAX_DEVICES;
    fsum = 0;
    for (int d = 0; d < n; d++) fsum += factor_tbl[d];
    avg = (fsum == 0) ? 64'd0 : {12'd0, cost_sum} / fsum;
    id = 0;
    for (int d = 0; d < n; d++) begin
      start = id;
      f = factor_tbl[d];
      r.out_device  = d[DEV_W-1:0];
      r.range_start = start[BCNT_W-1:0];
      if (d + 1 == n) begin
        r.range_end = blk_count[BCNT_W-1:0];
        r.last      = 1'b1;
        range_q.insert(range_q.size(), r);
        break;
      end
      acc = 0;
      while (acc < avg && id < blk_count) begin
        acc += (f == 0) ? {24'd0, {REF_W{1'b1}}} : {24'd0, ref_cost[id]} / f;
        id++;
      end
      r.range_end = id[BCNT_W-1:0];
      r.last      = 1'b0;
      range_q.insert(range_q.size(), r);
    end
  endtask

  task automatic apply_item(input wcp_in_t it);
    logic [REF_W-1:0] rc;
    case (it.op)
      OP_SET_FACTOR: factor_tbl[it.device_index] = it.device_factor;
      OP_LOAD_BLOCK: begin
        if (blk_count < MAX_BLOCKS) begin
          rc = REF_W'(it.block_cost) * REF_W'(it.owner_factor);
          ref_cost[blk_count] = rc;
          blk_count++;
          cost_sum = cost_sum + TOT_W'(rc);
        end
      end
      OP_RUN: begin
        run_count++;
        predict_partition();
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input wcp_in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(it);
    item_count++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic wcp_in_t mk_item(input logic [1:0] op);
    wcp_in_t it;
    it.op            = op;
    it.device_index  = DEV_W'($urandom);
    it.device_factor = FAC_W'($urandom_range(1, 255));
    it.block_cost    = $urandom;
    it.owner_factor  = FAC_W'($urandom_range(1, 255));
    return it;
  endfunction

  task automatic set_factor(input int unsigned idx, input int unsigned fac);
    wcp_in_t it;
    it = mk_item(OP_SET_FACTOR);
    it.device_index  = idx[DEV_W-1:0];
    it.device_factor = fac[FAC_W-1:0];
    send_item(it);
  endtask

  task automatic load_block(input logic [COST_W-1:0] cost, input int unsigned of);
    wcp_in_t it;
    it = mk_item(OP_LOAD_BLOCK);
    it.block_cost   = cost;
    it.owner_factor = of[FAC_W-1:0];
    send_item(it);
  endtask

  task automatic run_cmd();
    send_item(mk_item(OP_RUN));
  endtask

  // Hold until every range is out and the block is idle
  task automatic drain();
    while (range_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] val);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    dev_count   = val;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (range_q.size() == 0) begin
        $error("unexpected range transfer: device %0d", out_data.out_device);
        fail_count++;
      end else begin
        wcp_out_t e;
        e = range_q.pop_front();
        range_count++;
        if (out_data.out_device !== e.out_device) begin
          $error("out_device exp %0d got %0d", e.out_device, out_data.out_device);
          fail_count++;
        end
        if (out_data.range_start !== e.range_start) begin
          $error("range_start exp %0d got %0d", e.range_start, out_data.range_start);
          fail_count++;
        end
        if (out_data.range_end !== e.range_end) begin
          $error("range_end exp %0d got %0d", e.range_end, out_data.range_end);
          fail_count++;
        end
        if (out_data.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall = 1'b0;
      end
      @(negedge clk);
    end
  end

  // Every device gets a factor before any run reads it
  task automatic test_factor_setup();
    for (int d = 0; d < MAX_DEVICES; d++)
      set_factor(d, (d == 0) ? 255 : (d == 1) ? 1 : $urandom_range(1, 255));
  endtask

  task automatic test_extremes();
    write_count(7'd4);
    run_cmd();                          // no blocks: every range empty
    load_block(32'd0, 1);
    load_block(32'hFFFF_FFFF, 255);
    load_block(32'hFFFF_FFFF, 1);
    load_block(32'h0000_0001, 255);
    load_block(32'hAAAA_5555, 128);
    load_block(32'h5555_AAAA, 127);
    run_cmd();
    write_count(7'd64);
    run_cmd();                          // blocks run out well before the last device
    write_count(7'd1);
    run_cmd();
  endtask

  task automatic test_special_cases();
    wcp_in_t it;
    write_count(7'd0);                  // zero count acts as one
    run_cmd();
    write_count(7'd127);                // saturate to the device limit
    run_cmd();
    write_count(7'd65);
    run_cmd();
    write_count(7'd3);
    set_factor(1, 0);                   // zero factor saturates the quotient
    run_cmd();
    set_factor(0, 0);
    set_factor(1, 0);
    set_factor(2, 0);                   // zero factor sum
    run_cmd();
    it = mk_item(2'd3);                 // unused op, dropped
    send_item(it);
    set_factor(0, 200);
    set_factor(1, 3);
    set_factor(2, 90);
    run_cmd();
  endtask

  task automatic test_random();
    wcp_in_t     it;
    int unsigned sel;
    for (int i = 0; i < 230; i++) begin
      if (i % 80 == 79) write_count(7'($urandom_range(1, 64)));
      if (i == 190) begin
        drain();
        quiet = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 40 && blk_count < 90) begin
        it = mk_item(OP_LOAD_BLOCK);
        if ($urandom_range(0, 3) == 0) it.block_cost = it.block_cost >> $urandom_range(0, 31);
      end else if (sel < 85) begin
        it = mk_item(OP_SET_FACTOR);
      end else if (sel < 98) begin
        it = mk_item(OP_RUN);
      end else begin
        it = mk_item(2'd3);
      end
      send_item(it);
    end
    run_cmd();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    quiet       = 1'b0;
    fail_count  = 0;
    range_count = 0;
    run_count   = 0;
    item_count  = 0;
    blk_count   = 0;
    cost_sum    = '0;
    dev_count   = 7'd1;
    for (int d = 0; d < MAX_DEVICES; d++) factor_tbl[d] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_factor_setup();
    test_extremes();
    test_special_cases();
    test_random();
    drain();
    repeat (20) @(negedge clk);
    if (range_q.size() != 0) begin
      $error("%0d ranges never arrived", range_q.size());
      fail_count++;
    end
    $display("covered %0d items, %0d runs, %0d ranges checked, %0d blocks held",
             item_count, run_count, range_count, blk_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
src/wcp_pkg.sv
src/wcp_divider.sv
src/wcp_datapath.sv
src/wcp_controller.sv
src/weighted_contiguous_partition_unit.sv
tb/weighted_contiguous_partition_unit_test.sv
